>>> rtl/blrc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bilinear ratio and coefficient table generator.
// No dependencies.
package blrc_pkg;

	localparam int MAX_TERM_DEF = 20;   // largest numerator or denominator searched
	localparam int SIZE_W       = 12;   // width of a source or destination size
	localparam int FIELD_W      = 5;    // width of reported n, m and entry index
	localparam int WEIGHT_W     = 8;    // width of a weight (0 .. 128)

	typedef struct packed {
		logic [SIZE_W-1:0] src_size;
		logic [SIZE_W-1:0] dst_size;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0]  ratio_num;
		logic [FIELD_W-1:0]  ratio_den;
		logic [FIELD_W-1:0]  entry_index;
		logic [WEIGHT_W-1:0] weight;
		logic                advance;
		logic                last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_STEP   = 4'b0100,
		ST_WEIGHT = 4'b1000
	} state_t;

endpackage

>>> rtl/bilinear_ratio_and_coef_lut_generator.sv
`timescale 1ns / 1ps
// The search tries one candidate n/m per cycle through a two-stage multiply and compare pipe,
// then splits n by m with repeated subtraction, then runs a bit-serial divider for each entry;
// one item at a time, busy until the last entry.
// Each entry shows for one cycle on strobe; the receiver cannot stall.
// Reset (arst_n low) returns the sequencer to idle at once. Depends on blrc_pkg.
module bilinear_ratio_and_coef_lut_generator
	import blrc_pkg::*;
#(
	parameter int MAX_TERM = MAX_TERM_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic strobe,
	output rsp_t result
);

	localparam int TW  = $clog2(MAX_TERM + 1);     // holds 1 .. MAX_TERM
	localparam int EW  = SIZE_W + TW;              // error |s*m - n*d|
	localparam int PW  = EW + TW;                  // cross-multiplied error
	localparam int CW  = $clog2(WEIGHT_W);         // divider step counter
	localparam int FRAC = WEIGHT_W - 1;            // weight scale is 2^FRAC

	localparam logic [TW-1:0] TERM_MAX = TW'(MAX_TERM);
	localparam logic [TW-1:0] TERM_ONE = TW'(1);
	localparam logic [CW-1:0] STEP_LAST = CW'(FRAC);

	state_t state_q;

	logic [SIZE_W-1:0] src_q, dst_q;

	// search counters and pipe
	logic [TW-1:0] n_q, m_q;
	logic          issue_done_q;
	logic          v_s1;
	logic [EW-1:0] e_s1;
	logic [TW-1:0] n_s1, m_s1;

	// best candidate so far
	logic          have_q;
	logic [TW-1:0] best_n_q, best_m_q;
	logic [EW-1:0] best_e_q;

	// n = nq*m + nr
	logic [TW-1:0] nq_q, nr_q;

	// entry walk
	logic [TW-1:0] i_q, q_q, r_q;
	logic [TW:0]   t_q;
	logic [TW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic [FRAC-1:0] quot_q;

	logic  strobe_q;
	rsp_t  result_q;

	// candidate error, stage 1
	logic [EW-1:0] sm, nd, e_d;
	logic          cand_ok;
	assign sm      = EW'(src_q) * EW'(m_q);
	assign nd      = EW'(n_q) * EW'(dst_q);
	assign e_d     = (sm > nd) ? sm - nd : nd - sm;
	assign cand_ok = !issue_done_q && ({1'b0, n_q, 1'b0} >= {2'b00, m_q});

	// strictly-closer test, stage 2
	logic [PW-1:0] lhs, rhs;
	logic          better;
	assign lhs    = PW'(e_s1) * PW'(best_m_q);
	assign rhs    = PW'(best_e_q) * PW'(m_s1);
	assign better = v_s1 && (!have_q || lhs < rhs);

	// divider step for the weight
	logic [TW:0] trial, rem_d;
	logic        qbit;
	assign trial = (cnt_q == '0) ? rem_q : {rem_q[TW-1:0], 1'b0};
	assign qbit  = trial >= {1'b0, best_m_q};
	assign rem_d = qbit ? trial - {1'b0, best_m_q} : trial;

	// next entry phase
	logic [TW:0]   r_sum;
	logic          wrap;
	logic [TW-1:0] r_next, q_next;
	logic          adv, is_last;
	assign r_sum   = {1'b0, r_q} + {1'b0, nr_q};
	assign wrap    = r_sum >= {1'b0, best_m_q};
	assign r_next  = wrap ? TW'(r_sum - {1'b0, best_m_q}) : TW'(r_sum);
	assign q_next  = q_q + nq_q + TW'(wrap);
	assign adv     = t_q <= {1'b0, q_q};
	assign is_last = (TW'(i_q + TERM_ONE) == best_m_q);

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_done_q <= 1'b0;
			v_s1         <= 1'b0;
			have_q       <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			// mark the cycle after the last divider step
			strobe_q <= (state_q == ST_WEIGHT) && (cnt_q == STEP_LAST);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						src_q        <= request.src_size;
						dst_q        <= request.dst_size;
						n_q          <= TERM_ONE;
						m_q          <= TERM_ONE;
						issue_done_q <= 1'b0;
						v_s1         <= 1'b0;
						have_q       <= 1'b0;
						state_q      <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// issue one candidate, judge the previous one
					v_s1 <= cand_ok;
					e_s1 <= e_d;
					n_s1 <= n_q;
					m_s1 <= m_q;
					if (!issue_done_q) begin
						if (m_q == TERM_MAX) begin
							m_q <= TERM_ONE;
							n_q <= n_q + TERM_ONE;
							if (n_q == TERM_MAX)
								issue_done_q <= 1'b1;
						end else begin
							m_q <= m_q + TERM_ONE;
						end
					end
					if (better) begin
						have_q   <= 1'b1;
						best_n_q <= n_s1;
						best_m_q <= m_s1;
						best_e_q <= e_s1;
					end
					if (issue_done_q && !v_s1) begin
						nq_q    <= '0;
						nr_q    <= best_n_q;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					// split n by m with repeated subtraction
					if (nr_q >= best_m_q) begin
						nr_q <= nr_q - best_m_q;
						nq_q <= nq_q + TERM_ONE;
					end else begin
						i_q     <= '0;
						q_q     <= '0;
						r_q     <= '0;
						t_q     <= '0;
						rem_q   <= {1'b0, best_m_q};
						cnt_q   <= '0;
						state_q <= ST_WEIGHT;
					end
				end
				ST_WEIGHT: begin
					// one quotient bit of 2^FRAC*(m-r)/m per cycle
					quot_q <= {quot_q[FRAC-2:0], qbit};
					if (cnt_q == STEP_LAST) begin
						result_q.ratio_num   <= FIELD_W'(best_n_q);
						result_q.ratio_den   <= FIELD_W'(best_m_q);
						result_q.entry_index <= FIELD_W'(i_q);
						result_q.weight      <= {quot_q, qbit};
						result_q.advance     <= adv;
						result_q.last        <= is_last;
						t_q   <= t_q + (TW+1)'(adv);
						i_q   <= i_q + TERM_ONE;
						q_q   <= q_next;
						r_q   <= r_next;
						rem_q <= {1'b0, best_m_q} - {1'b0, r_next};
						cnt_q <= '0;
						if (is_last)
							state_q <= ST_IDLE;
					end else begin
						rem_q <= rem_d;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> bench/bilinear_ratio_and_coef_lut_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the bilinear ratio and coefficient table generator: a burst driver
// issues size requests, a monitor checks every coefficient entry against a local predictor.
// Depends on blrc_pkg and bilinear_ratio_and_coef_lut_generator.
module bilinear_ratio_and_coef_lut_generator_tb;
	import blrc_pkg::*;

	parameter int TERMS = MAX_TERM_DEF;
	// one full request: search, split and per-entry divides, with margin
	localparam int TAIL_CYCLES = 2 * TERMS * TERMS + 12 * TERMS + 200;
	localparam int RANDOM_ITEMS = 480;

	typedef struct {
		req_t req;
		bit   drain;    // hold this item until the block has gone quiet
	} size_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy, strobe;
	rsp_t result;

	size_item_t size_q[$];      // requests not yet handed to the block
	rsp_t       coef_q[$];      // coefficient entries still owed by the block
	int         errors = 0;
	int         n_sent = 0;
	int         n_entries = 0;
	int         widest = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	logic       drv_go;
	req_t       drv_next;
	size_item_t drv_item;
	rsp_t       want;

	bilinear_ratio_and_coef_lut_generator #(.MAX_TERM(TERMS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.strobe  (strobe),
		.result  (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Find the nearest n/m to src/dst and queue the m table entries it produces.
	function automatic void predict_table(req_t r);
		longint s, d, e, best_e;
		int best_n, best_m, t, p;
		bit found;
		rsp_t x;
		s = r.src_size;
		d = r.dst_size;
		found = 0;
		best_n = 0;
		best_m = 0;
		best_e = 0;
		for (int n = 1; n <= TERMS; n++) begin
			for (int m = 1; m <= TERMS; m++) begin
				if (2 * n < m)
					continue;
				e = (s * m > n * d) ? s * m - n * d : n * d - s * m;
				// replace only on a strictly closer ratio, so the earliest of a tie stays
				if (!found || e * best_m < best_e * m) begin
					found = 1;
					best_n = n;
					best_m = m;
					best_e = e;
				end
			end
		end
		t = 0;
		for (int i = 0; i < best_m; i++) begin
			p = i * best_n;
			x.ratio_num = FIELD_W'(best_n);
			x.ratio_den = FIELD_W'(best_m);
			x.entry_index = FIELD_W'(i);
			x.weight = WEIGHT_W'((128 * (best_m - p % best_m)) / best_m);
			x.advance = (t <= p / best_m);
			if (x.advance)
				t++;
			x.last = (i == best_m - 1);
			coef_q.push_back(x);
		end
		if (best_m > widest)
			widest = best_m;
	endfunction

	function automatic void check_field(string name, logic [WEIGHT_W-1:0] want_v,
			logic [WEIGHT_W-1:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
		end
	endfunction

	function automatic void add_request(int s, int d, bit drain);
		size_item_t it;
		it.req.src_size = SIZE_W'(s);
		it.req.dst_size = SIZE_W'(d);
		it.drain = drain;
		size_q.push_back(it);
	endfunction

	// Driver: hand items over in bursts, with random gaps and an occasional full drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			drv_go = start;
			drv_next = request;
			if (start && !busy) begin
				predict_table(request);
				n_sent++;
				drv_go = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					case ($urandom_range(0, 4))
					0, 1: gap_left = 0;
					2, 3: gap_left = $urandom_range(1, 30);
					default: gap_left = $urandom_range(31, 600);
					endcase
				end
			end
			if (!drv_go && size_q.size() != 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!size_q[0].drain || (!busy && coef_q.size() == 0)) begin
					drv_item = size_q.pop_front();
					drv_next = drv_item.req;
					drv_go = 1'b1;
				end
			end
			start <= drv_go;
			request <= drv_next;
		end
	end

	// Monitor: every strobed entry must match the oldest owed entry.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			n_entries++;
			if (coef_q.size() == 0) begin
				errors++;
				$display("%0t: entry with none expected: expected nothing, actual %p",
					$time, result);
			end else begin
				want = coef_q.pop_front();
				check_field("ratio_num", WEIGHT_W'(want.ratio_num),
					WEIGHT_W'(result.ratio_num));
				check_field("ratio_den", WEIGHT_W'(want.ratio_den),
					WEIGHT_W'(result.ratio_den));
				check_field("entry_index", WEIGHT_W'(want.entry_index),
					WEIGHT_W'(result.entry_index));
				check_field("weight", want.weight, result.weight);
				check_field("advance", WEIGHT_W'(want.advance), WEIGHT_W'(result.advance));
				check_field("last", WEIGHT_W'(want.last), WEIGHT_W'(result.last));
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int n, m, k, s, d;
		// corners: zero sizes, full scale, ratio bounds, ties and bit patterns
		add_request(0, 0, 0);
		add_request(7, 0, 0);
		add_request(0, 9, 0);
		add_request(4095, 0, 0);
		add_request(1, 1, 1);
		add_request(4095, 4095, 0);
		add_request(4095, 1, 0);
		add_request(1, 4095, 0);
		add_request(1, 2, 0);
		add_request(2, 1, 0);
		add_request(20, 1, 0);
		add_request(19, 20, 0);
		add_request(20, 19, 0);
		add_request(3, 7, 0);
		add_request(17, 19, 0);
		add_request(13, 20, 0);
		add_request(4095, 2048, 0);
		add_request(2048, 4095, 0);
		add_request(12'hAAA, 12'h555, 0);
		add_request(12'h555, 12'hAAA, 0);
		add_request(12'hFFF, 12'h800, 0);
		add_request(1000, 1999, 0);

		for (int j = 0; j < RANDOM_ITEMS; j++) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				// exact multiples of a valid ratio, often nudged by one
				n = $urandom_range(1, TERMS);
				m = $urandom_range(1, (2 * n < TERMS) ? 2 * n : TERMS);
				k = $urandom_range(1, 4095 / ((n > m) ? n : m));
				s = n * k;
				d = m * k;
				case ($urandom_range(0, 4))
				0: s = s + 1;
				1: d = d + 1;
				2: s = s - 1;
				3: d = d - 1;
				default: ;
				endcase
			end
			5, 6, 7: begin
				s = $urandom_range(1, 4095);
				d = $urandom_range(1, 4095);
			end
			8: begin
				s = $urandom_range(0, 40);
				d = $urandom_range(0, 40);
			end
			default: begin
				// far outside the searchable range on either side
				if ($urandom_range(0, 1)) begin
					s = $urandom_range(0, 15);
					d = $urandom_range(1000, 4095);
				end else begin
					s = $urandom_range(1000, 4095);
					d = $urandom_range(0, 15);
				end
			end
			endcase
			if (s > 4095)
				s = 4095;
			add_request(s, d, (j % 120) == 60);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (size_q.size() != 0 || start || coef_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Ran %0d size requests (zero and full-scale sizes, exact and near ratios,",
			n_sent);
		$display("out-of-range ratios) and checked %0d table entries, up to %0d per table.",
			n_entries, widest);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("%0t: timeout with %0d requests unsent and %0d entries owed",
			$time, size_q.size(), coef_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
